/* design/tfn_pkg.sv */
// Package with the types and constants of the triangle face normal pipeline.
`default_nettype none
package tfn_pkg;
  localparam int COORD_BITS  = 24;
  localparam int NORMAL_BITS = 16;
  localparam int FRAC        = NORMAL_BITS - 2;
  localparam int DIFF_W      = COORD_BITS + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int MAG_W       = PROD_W;
  localparam int LEN_W       = $clog2(MAG_W + 1);
  localparam int V_W         = 30;
  localparam int SQ_W        = 2 * V_W + 2;
  localparam int ROOT_W      = SQ_W / 2;
  localparam int REM_W       = ROOT_W + 3;
  localparam int Q_W         = FRAC + 1;
  localparam int NUM_W       = V_W + Q_W + 1;
  localparam int DEN_W       = ROOT_W + 1;
  localparam int DREM_W      = DEN_W + 1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] az;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by_coord;
    logic signed [COORD_BITS-1:0] bz;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] cz;
  } in_t;

  typedef struct packed {
    logic signed [NORMAL_BITS-1:0] nx;
    logic signed [NORMAL_BITS-1:0] ny;
    logic signed [NORMAL_BITS-1:0] nz;
    logic                          degenerate;
  } out_t;

  typedef struct packed {
    logic [2:0][V_W-1:0] v;
    logic [2:0]          neg;
    logic                dgn;
  } carry_t;
endpackage
`default_nettype wire

/* design/triangle_face_normal.sv */
// Top level of the pipelined unit face normal of a triangle.
//
// A triangle is transferred in at a rising edge where start is high and busy
// is low. The vertices arrive on the vertices port as signed Q12.12 values.
// busy is always low, so one triangle can be transferred every cycle.
// Each triangle yields one result on the result port, marked by done for
// exactly one cycle, with the unit normal in signed Q2.14 and a degenerate
// flag for collinear or coincident vertices.
// done and the result come from the last stage of the pipeline. The pipeline is
// made of the edge and cross product stages, the normalization, a square root
// that resolves one root bit per stage and three dividers that resolve one
// quotient bit per stage. Throughput is one triangle per cycle.
// The receiver cannot stall; every result is presented for one cycle only.
// A synchronous reset clears all valid bits, so nothing in flight is
// delivered after reset.
`default_nettype none
module triangle_face_normal (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  output logic              busy,
  input  tfn_pkg::in_t      vertices,
  output logic              done,
  output tfn_pkg::out_t     result
);
  localparam int SQ_STEPS  = tfn_pkg::ROOT_W;
  localparam int DIV_STEPS = tfn_pkg::Q_W;
  localparam int FRONT     = 7;
  localparam int NSTAGE    = FRONT + SQ_STEPS + 1 + DIV_STEPS + 1;

  logic [NSTAGE-1:0] vld;

  logic signed [2:0][tfn_pkg::DIFF_W-1:0] dab, dac;
  logic signed [2:0][tfn_pkg::PROD_W-1:0] pp, pq;
  logic [2:0][tfn_pkg::MAG_W-1:0]         mag3, mag4;
  logic [2:0]                              neg3, neg4;
  logic [tfn_pkg::LEN_W-1:0]               len4;
  tfn_pkg::carry_t                         c5, c6;
  logic [2:0][2*tfn_pkg::V_W-1:0]          sqr6;

  tfn_pkg::carry_t                         sc [0:SQ_STEPS];
  logic [tfn_pkg::SQ_W-1:0]                sx [0:SQ_STEPS];
  logic [tfn_pkg::REM_W-1:0]               srem [0:SQ_STEPS];
  logic [tfn_pkg::ROOT_W-1:0]              sroot [0:SQ_STEPS];

  tfn_pkg::carry_t                         dc [0:DIV_STEPS];
  logic [tfn_pkg::DEN_W-1:0]               dden [0:DIV_STEPS];
  logic [2:0][tfn_pkg::DREM_W-1:0]         drem [0:DIV_STEPS];
  logic [2:0][tfn_pkg::Q_W-1:0]            dlow [0:DIV_STEPS];
  logic [2:0][tfn_pkg::Q_W-1:0]            dq [0:DIV_STEPS];

  assign busy = 1'b0;
  assign done = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NSTAGE-2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    logic signed [tfn_pkg::PROD_W:0] cr;
    logic [tfn_pkg::MAG_W-1:0]       orv;
    logic [tfn_pkg::LEN_W-1:0]       ln;
    logic [tfn_pkg::MAG_W-1:0]       sh;
    dab[0] <= tfn_pkg::DIFF_W'(vertices.bx) - tfn_pkg::DIFF_W'(vertices.ax);
    dab[1] <= tfn_pkg::DIFF_W'(vertices.by_coord) - tfn_pkg::DIFF_W'(vertices.ay);
    dab[2] <= tfn_pkg::DIFF_W'(vertices.bz) - tfn_pkg::DIFF_W'(vertices.az);
    dac[0] <= tfn_pkg::DIFF_W'(vertices.cx) - tfn_pkg::DIFF_W'(vertices.ax);
    dac[1] <= tfn_pkg::DIFF_W'(vertices.cy) - tfn_pkg::DIFF_W'(vertices.ay);
    dac[2] <= tfn_pkg::DIFF_W'(vertices.cz) - tfn_pkg::DIFF_W'(vertices.az);

    pp[0] <= $signed(dab[1]) * $signed(dac[2]);
    pq[0] <= $signed(dab[2]) * $signed(dac[1]);
    pp[1] <= $signed(dab[2]) * $signed(dac[0]);
    pq[1] <= $signed(dab[0]) * $signed(dac[2]);
    pp[2] <= $signed(dab[0]) * $signed(dac[1]);
    pq[2] <= $signed(dab[1]) * $signed(dac[0]);

    for (int i = 0; i < 3; i++) begin
      cr = (tfn_pkg::PROD_W+1)'($signed(pp[i])) - (tfn_pkg::PROD_W+1)'($signed(pq[i]));
      neg3[i] <= cr[tfn_pkg::PROD_W];
      mag3[i] <= cr[tfn_pkg::PROD_W] ? tfn_pkg::MAG_W'(-cr) : tfn_pkg::MAG_W'(cr);
    end

    orv = mag3[0] | mag3[1] | mag3[2];
    ln = '0;
    for (int k = 0; k < tfn_pkg::MAG_W; k++) begin
      if (orv[k]) ln = tfn_pkg::LEN_W'(k + 1);
    end
    len4 <= ln;
    mag4 <= mag3;
    neg4 <= neg3;

    for (int i = 0; i < 3; i++) begin
      if (len4 > tfn_pkg::LEN_W'(tfn_pkg::V_W)) begin
        sh = mag4[i] >> (len4 - tfn_pkg::LEN_W'(tfn_pkg::V_W));
      end else begin
        sh = mag4[i] << (tfn_pkg::LEN_W'(tfn_pkg::V_W) - len4);
      end
      c5.v[i] <= sh[tfn_pkg::V_W-1:0];
    end
    c5.neg <= neg4;
    c5.dgn <= (len4 == '0);

    for (int i = 0; i < 3; i++) begin
      sqr6[i] <= c5.v[i] * c5.v[i];
    end
    c6 <= c5;
  end

  always_ff @(posedge clk) begin
    logic [tfn_pkg::REM_W-1:0] r2, t;
    sx[0]    <= tfn_pkg::SQ_W'(sqr6[0]) + tfn_pkg::SQ_W'(sqr6[1]) + tfn_pkg::SQ_W'(sqr6[2]);
    sc[0]    <= c6;
    srem[0]  <= '0;
    sroot[0] <= '0;
    for (int k = 0; k < SQ_STEPS; k++) begin
      r2 = {srem[k][tfn_pkg::REM_W-3:0], sx[k][tfn_pkg::SQ_W-1 -: 2]};
      t  = {1'b0, sroot[k], 2'b01};
      if (r2 >= t) begin
        srem[k+1]  <= r2 - t;
        sroot[k+1] <= {sroot[k][tfn_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        srem[k+1]  <= r2;
        sroot[k+1] <= {sroot[k][tfn_pkg::ROOT_W-2:0], 1'b0};
      end
      sx[k+1] <= sx[k] << 2;
      sc[k+1] <= sc[k];
    end
  end

  always_ff @(posedge clk) begin
    logic [tfn_pkg::NUM_W-1:0]  num;
    logic [tfn_pkg::DREM_W-1:0] r2;
    for (int i = 0; i < 3; i++) begin
      num = {1'b0, sc[SQ_STEPS].v[i], {tfn_pkg::Q_W{1'b0}}}
          + tfn_pkg::NUM_W'(sroot[SQ_STEPS]);
      drem[0][i] <= tfn_pkg::DREM_W'(num[tfn_pkg::NUM_W-1:tfn_pkg::Q_W]);
      dlow[0][i] <= num[tfn_pkg::Q_W-1:0];
      dq[0][i]   <= '0;
    end
    dden[0] <= {sroot[SQ_STEPS], 1'b0};
    dc[0]   <= sc[SQ_STEPS];
    for (int k = 0; k < DIV_STEPS; k++) begin
      for (int i = 0; i < 3; i++) begin
        r2 = {drem[k][i][tfn_pkg::DREM_W-2:0], dlow[k][i][tfn_pkg::Q_W-1]};
        if (r2 >= tfn_pkg::DREM_W'(dden[k])) begin
          drem[k+1][i] <= r2 - tfn_pkg::DREM_W'(dden[k]);
          dq[k+1][i]   <= {dq[k][i][tfn_pkg::Q_W-2:0], 1'b1};
        end else begin
          drem[k+1][i] <= r2;
          dq[k+1][i]   <= {dq[k][i][tfn_pkg::Q_W-2:0], 1'b0};
        end
        dlow[k+1][i] <= dlow[k][i] << 1;
      end
      dden[k+1] <= dden[k];
      dc[k+1]   <= dc[k];
    end
  end

  always_ff @(posedge clk) begin
    logic [2:0][tfn_pkg::NORMAL_BITS-1:0] o;
    for (int i = 0; i < 3; i++) begin
      if (dc[DIV_STEPS].dgn) begin
        o[i] = '0;
      end else if (dc[DIV_STEPS].neg[i]) begin
        o[i] = -tfn_pkg::NORMAL_BITS'(dq[DIV_STEPS][i]);
      end else begin
        o[i] = tfn_pkg::NORMAL_BITS'(dq[DIV_STEPS][i]);
      end
    end
    result.nx         <= o[0];
    result.ny         <= o[1];
    result.nz         <= o[2];
    result.degenerate <= dc[DIV_STEPS].dgn;
  end
endmodule
`default_nettype wire

/* tb/sv/tb_triangle_face_normal.sv */
// Self-checking testbench for the pipelined unit face normal of a triangle.
`default_nettype none
module tb_triangle_face_normal;
  localparam int LATENCY = 55;
  localparam logic signed [23:0] CMAX = 24'sh7fffff;
  localparam logic signed [23:0] CMIN = -24'sh800000;

  typedef struct {
    tfn_pkg::in_t  tri_in;
    logic          known;
    tfn_pkg::out_t want;
  } row_t;

  logic          clk;
  logic          rst;
  logic          start;
  logic          busy;
  tfn_pkg::in_t  vertices;
  logic          done;
  tfn_pkg::out_t result;

  tfn_pkg::out_t normal_q[$];
  int            mismatches;
  int            sender_idle_pct;
  row_t          rows[$];

  triangle_face_normal dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .vertices(vertices), .done(done), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #30000000;
    $display("[triangle_face_normal] ERROR");
    $finish;
  end

  function automatic logic [63:0] root_of(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x = x - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  function automatic tfn_pkg::out_t unit_normal(tfn_pkg::in_t t);
    logic signed [24:0]  ab[3];
    logic signed [24:0]  ac[3];
    logic signed [67:0]  cr[3];
    logic        [67:0]  mag[3];
    logic        [63:0]  v[3];
    logic        [63:0]  s;
    logic        [63:0]  len_root;
    logic        [63:0]  q;
    logic signed [15:0]  comp[3];
    int                  maxlen;
    int                  i;
    tfn_pkg::out_t       o;
    ab[0] = 25'(t.bx) - 25'(t.ax);
    ab[1] = 25'(t.by_coord) - 25'(t.ay);
    ab[2] = 25'(t.bz) - 25'(t.az);
    ac[0] = 25'(t.cx) - 25'(t.ax);
    ac[1] = 25'(t.cy) - 25'(t.ay);
    ac[2] = 25'(t.cz) - 25'(t.az);
    cr[0] = 68'(ab[1]) * 68'(ac[2]) - 68'(ab[2]) * 68'(ac[1]);
    cr[1] = 68'(ab[2]) * 68'(ac[0]) - 68'(ab[0]) * 68'(ac[2]);
    cr[2] = 68'(ab[0]) * 68'(ac[1]) - 68'(ab[1]) * 68'(ac[0]);
    maxlen = 0;
    for (i = 0; i < 3; i++) begin
      mag[i] = cr[i] < 0 ? 68'(-cr[i]) : 68'(cr[i]);
      for (int b = 0; b < 68; b++) if (mag[i][b] && b + 1 > maxlen) maxlen = b + 1;
    end
    o = '0;
    if (maxlen == 0) begin
      o.degenerate = 1'b1;
      return o;
    end
    s = 0;
    for (i = 0; i < 3; i++) begin
      if (maxlen > 30) v[i] = 64'(mag[i] >> (maxlen - 30));
      else v[i] = 64'(mag[i] << (30 - maxlen));
      s = s + v[i] * v[i];
    end
    len_root = root_of(s);
    for (i = 0; i < 3; i++) begin
      q = ((v[i] << 15) + len_root) / (2 * len_root);
      if (cr[i] < 0) q = -q;
      comp[i] = q[15:0];
    end
    o.nx = comp[0];
    o.ny = comp[1];
    o.nz = comp[2];
    return o;
  endfunction

  function automatic tfn_pkg::in_t rand_triangle(int mode);
    tfn_pkg::in_t t;
    logic signed [23:0] c[9];
    int range;
    range = (mode == 0) ? 0 : (mode == 1 ? 12 : 24);
    for (int i = 0; i < 9; i++) begin
      c[i] = (range == 24) ? 24'($urandom) : 24'($signed($urandom_range(0, 1 << range)) -
             (1 << (range - 1 > 0 ? range - 1 : 0)));
    end
    if (mode == 0) begin
      // Collinear: c = a + k*(b - a).
      for (int i = 0; i < 6; i++) c[i] = 24'($signed($urandom_range(0, 2000)) - 1000);
      for (int i = 0; i < 3; i++) c[6 + i] = c[i] + 24'(2) * (c[3 + i] - c[i]);
    end
    t = {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8]};
    return t;
  endfunction

  // Leaves start high; the caller lowers it when no transfer follows.
  task automatic send_triangle(tfn_pkg::in_t t);
    logic was_busy;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    vertices <= t;
    forever begin
      was_busy = busy;
      @(posedge clk);
      if (!was_busy) break;
    end
    normal_q.push_back(unit_normal(t));
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (normal_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer out: %p", result);
      end else begin
        tfn_pkg::out_t w;
        w = normal_q.pop_front();
        if (result.nx !== w.nx || result.ny !== w.ny || result.nz !== w.nz ||
            result.degenerate !== w.degenerate) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", w, result);
        end
      end
    end
  end

  initial begin
    row_t r;
    int   waited;
    rst = 1'b1;
    start = 1'b0;
    vertices = '0;
    mismatches = 0;
    sender_idle_pct = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    r.known = 1'b1;
    r.want = '{nx: 16'sd0, ny: 16'sd0, nz: 16'sd0, degenerate: 1'b1};
    r.tri_in = '0; rows.push_back(r);
    r.tri_in = {CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}; rows.push_back(r);
    r.tri_in = {CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN}; rows.push_back(r);
    r.tri_in = {24'sd0, 24'sd0, 24'sd0, 24'sd1, 24'sd1, 24'sd1, 24'sd2, 24'sd2, 24'sd2};
    rows.push_back(r);
    r.want = '{nx: 16'sd0, ny: 16'sd0, nz: 16'sd16384, degenerate: 1'b0};
    r.tri_in = {24'sd0, 24'sd0, 24'sd0, 24'sd4096, 24'sd0, 24'sd0, 24'sd0, 24'sd4096, 24'sd0};
    rows.push_back(r);
    r.want = '{nx: 16'sd16384, ny: 16'sd0, nz: 16'sd0, degenerate: 1'b0};
    r.tri_in = {24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd1, 24'sd0, 24'sd0, 24'sd0, 24'sd1};
    rows.push_back(r);
    r.want = '{nx: 16'sd0, ny: -16'sd16384, nz: 16'sd0, degenerate: 1'b0};
    r.tri_in = {24'sd0, 24'sd0, 24'sd0, 24'sd1, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd1};
    rows.push_back(r);
    r.known = 1'b0;
    r.tri_in = {CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN}; rows.push_back(r);
    r.tri_in = {CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN}; rows.push_back(r);
    r.tri_in = {CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN}; rows.push_back(r);
    r.tri_in = {CMAX, CMIN, 24'sd0, 24'sd0, CMAX, CMIN, CMIN, 24'sd0, CMAX}; rows.push_back(r);
    r.tri_in = {24'sd0, 24'sd0, 24'sd0, 24'sd1, 24'sd0, 24'sd0, 24'sd1, 24'sd1, 24'sd0};
    rows.push_back(r);
    r.tri_in = {24'sd0, 24'sd0, 24'sd0, 24'sd1, 24'sd0, 24'sd0, 24'sd0, CMAX, 24'sd0};
    rows.push_back(r);
    r.tri_in = {24'sd5, -24'sd3, 24'sd7, -24'sd2, 24'sd9, 24'sd1, 24'sd4, 24'sd4, -24'sd6};
    rows.push_back(r);

    foreach (rows[i]) begin
      if (rows[i].known && unit_normal(rows[i].tri_in) !== rows[i].want) begin
        mismatches++;
        if (mismatches <= 10) $display("table row %0d disagrees with predictor", i);
      end
      send_triangle(rows[i].tri_in);
    end

    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 36 : (phase == 1 ? 62 : 0);
      for (int n = 0; n < 230; n++) begin
        send_triangle(rand_triangle($urandom_range(0, 9) == 0 ? 0 :
                                    ($urandom_range(0, 2) == 0 ? 1 : 2)));
        if (phase == 1 && n == 100) begin
          start <= 1'b0;
          while (normal_q.size() != 0) @(negedge clk);
        end
      end
    end
    start <= 1'b0;

    waited = 0;
    while (normal_q.size() != 0 && waited < 10 * LATENCY) begin
      @(negedge clk);
      waited++;
    end
    repeat (LATENCY + 10) @(negedge clk);
    if (mismatches == 0 && normal_q.size() == 0) begin
      $display("[triangle_face_normal] OK");
    end else begin
      $display("[triangle_face_normal] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
